// File: src/lzd_pkg.sv
// Shared types and constants for the LZ77 byte decompressor.
// No dependencies; imported by every module of the block but lzd_ram.
`timescale 1ns / 1ps

package lzd_pkg;

	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int BEAT_BYTES_DEF    = 4;

	// Configuration register indexes.
	localparam logic REG_IN_LENGTH = 1'b0;
	localparam logic REG_OUT_LIMIT = 1'b1;

	// Frame status codes.
	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_LIT   = 3'd1;
	localparam logic [2:0] STAT_TRUNC = 3'd2;
	localparam logic [2:0] STAT_REF   = 3'd3;
	localparam logic [2:0] STAT_OVFL  = 3'd4;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_OFFLO,
		PH_LEN
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_PUSH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic wr;
		logic push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic start_copy;
		logic beat_ready;
		logic copy_end;
	} dp_status_t;

endpackage

// File: src/lzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/lzd_ctrl.sv
// Controller state machine of the decompressor: input acceptance and copy sequencing.
// Depends on lzd_pkg.
`timescale 1ns / 1ps

module lzd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lzd_pkg::dp_status_t st,
	output lzd_pkg::ctrl_cmd_t  cmd
);

	import lzd_pkg::*;

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = !st.out_free;
				cmd.accept = in_valid && st.out_free;
				if (cmd.accept && st.start_copy) begin
					state_n = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_n = ST_WR;
			end
			ST_WR: begin
				cmd.wr  = 1'b1;
				state_n = st.beat_ready ? ST_PUSH : ST_RD;
			end
			ST_PUSH: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_n  = st.copy_end ? ST_IDLE : ST_RD;
				end
			end
		endcase
	end

endmodule

// File: src/lzd_dp.sv
// Datapath of the decompressor: token decoding, history store, beat assembly, output register.
// Depends on lzd_pkg and lzd_ram.
`timescale 1ns / 1ps

module lzd_dp #(
	parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
	parameter int BEAT_BYTES    = lzd_pkg::BEAT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic [7:0]          in_byte,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          out_byte0,
	output logic [7:0]          out_byte1,
	output logic [7:0]          out_byte2,
	output logic [7:0]          out_byte3,
	output logic [2:0]          byte_count,
	output logic                run_last,
	output logic                frame_done,
	output logic [2:0]          status,
	output logic [10:0]         total_out,
	input  lzd_pkg::ctrl_cmd_t  cmd,
	output lzd_pkg::dp_status_t st
);

	import lzd_pkg::*;

	localparam int AW       = $clog2(HISTORY_DEPTH);
	localparam int BEAT_USE = (BEAT_BYTES > 4) ? 4 : BEAT_BYTES;

	logic [15:0]   in_length_q;
	logic [10:0]   out_limit_q;
	logic [10:0]   out_pos_q;
	logic [15:0]   in_pos_q;
	phase_t        phase_q;
	logic [6:0]    lit_left_q;
	logic [15:0]   offset_q;
	logic          absorb_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    copy_left_q;
	logic [2:0]    fill_q;
	logic [7:0]    beat_q [4];
	logic          last_q;
	logic          out_valid_q;
	logic [7:0]    out_b_q [4];
	logic [2:0]    count_q;
	logic          run_last_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [10:0]   total_q;

	logic [15:0]   in_pos_n;
	logic          last;
	logic [15:0]   left;
	phase_t        phase_n;
	logic [6:0]    lit_left_n;
	logic [15:0]   offset_n;
	logic          err;
	logic [2:0]    err_code;
	logic          lit;
	logic          copy;
	logic          fin;
	logic [2:0]    fin_stat;
	logic [AW-1:0] wr_addr_inc;
	logic [16:0]   rd_diff;
	logic [16:0]   rd_fix;
	logic [7:0]    rdata;
	logic          ram_we;

	// Token decode for the byte offered at the input.
	always_comb begin
		in_pos_n   = in_pos_q + 16'd1;
		last       = in_pos_n >= in_length_q;
		left       = last ? 16'd0 : in_length_q - in_pos_n;
		phase_n    = phase_q;
		lit_left_n = lit_left_q;
		offset_n   = offset_q;
		err        = 1'b0;
		err_code   = STAT_OK;
		lit        = 1'b0;
		copy       = 1'b0;
		unique case (phase_q)
			PH_FLAG: begin
				if (!in_byte[7]) begin
					if ({9'd0, in_byte[6:0]} > left ||
					    ({1'b0, out_pos_q} + {5'd0, in_byte[6:0]}) > {1'b0, out_limit_q}) begin
						err      = 1'b1;
						err_code = STAT_LIT;
					end else if (in_byte[6:0] != 7'd0) begin
						phase_n    = PH_LIT;
						lit_left_n = in_byte[6:0];
					end
				end else if (left < 16'd2) begin
					err      = 1'b1;
					err_code = STAT_TRUNC;
				end else begin
					offset_n = {1'b0, in_byte[6:0], 8'h00};
					phase_n  = PH_OFFLO;
				end
			end
			PH_LIT: begin
				lit        = 1'b1;
				lit_left_n = lit_left_q - 7'd1;
				if (lit_left_q == 7'd1) begin
					phase_n = PH_FLAG;
				end
			end
			PH_OFFLO: begin
				offset_n = (offset_q | {8'h00, in_byte}) + 16'd1;
				phase_n  = PH_LEN;
			end
			PH_LEN: begin
				phase_n = PH_FLAG;
				if (in_byte == 8'd0 || offset_q > {5'd0, out_pos_q}) begin
					err      = 1'b1;
					err_code = STAT_REF;
				end else if (({1'b0, out_pos_q} + {4'd0, in_byte}) > {1'b0, out_limit_q}) begin
					err      = 1'b1;
					err_code = STAT_OVFL;
				end else begin
					copy = 1'b1;
				end
			end
		endcase
		fin = err || last;
		if (err) begin
			fin_stat = err_code;
		end else if (phase_n == PH_LIT) begin
			fin_stat = STAT_LIT;
		end else if (phase_n != PH_FLAG) begin
			fin_stat = STAT_TRUNC;
		end else begin
			fin_stat = STAT_OK;
		end
	end

	assign wr_addr_inc = (wr_addr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_addr_q + 1'b1;

	// Copy source: write position minus offset, wrapped into the store.
	assign rd_diff = {{(17 - AW){1'b0}}, wr_addr_q} - {1'b0, offset_q};
	assign rd_fix  = rd_diff[16] ? rd_diff + 17'(HISTORY_DEPTH) : rd_diff;

	assign ram_we = (cmd.accept && !absorb_q && lit) || cmd.wr;

	lzd_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr_q),
		.wdata(cmd.wr ? rdata : in_byte),
		.re   (cmd.rd),
		.raddr(rd_fix[AW-1:0]),
		.rdata(rdata)
	);

	assign st.out_free   = !out_valid_q || !out_stall;
	assign st.start_copy = !absorb_q && copy;
	assign st.beat_ready = (fill_q + 3'd1 == 3'(BEAT_USE)) || (copy_left_q == 8'd1);
	assign st.copy_end   = copy_left_q == 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_length_q <= 16'd1;
			out_limit_q <= 11'd1024;
			out_pos_q   <= '0;
			in_pos_q    <= '0;
			phase_q     <= PH_FLAG;
			lit_left_q  <= '0;
			offset_q    <= '0;
			absorb_q    <= 1'b0;
			wr_addr_q   <= '0;
			copy_left_q <= '0;
			fill_q      <= '0;
			beat_q      <= '{default: 8'd0};
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_b_q     <= '{default: 8'd0};
			count_q     <= '0;
			run_last_q  <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= STAT_OK;
			total_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IN_LENGTH: in_length_q <= cfg_wdata;
					REG_OUT_LIMIT: out_limit_q <= cfg_wdata[10:0];
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.accept) begin
				if (absorb_q) begin
					if (last) begin
						in_pos_q <= '0;
						absorb_q <= 1'b0;
						out_pos_q <= '0;
						wr_addr_q <= '0;
						offset_q  <= '0;
					end else begin
						in_pos_q <= in_pos_n;
					end
				end else begin
					in_pos_q   <= in_pos_n;
					phase_q    <= phase_n;
					lit_left_q <= lit_left_n;
					offset_q   <= offset_n;
					if (lit) begin
						out_pos_q <= out_pos_q + 11'd1;
						wr_addr_q <= wr_addr_inc;
					end
					if (copy) begin
						copy_left_q <= in_byte;
						fill_q      <= '0;
						beat_q      <= '{default: 8'd0};
						last_q      <= last;
					end
					if (lit || (fin && !copy)) begin
						out_valid_q <= 1'b1;
						out_b_q     <= '{lit ? in_byte : 8'd0, 8'd0, 8'd0, 8'd0};
						count_q     <= lit ? 3'd1 : 3'd0;
						run_last_q  <= 1'b1;
						done_q      <= fin;
						status_q    <= fin ? fin_stat : STAT_OK;
						total_q     <= fin ? (lit ? out_pos_q + 11'd1 : out_pos_q) : 11'd0;
					end
					if (fin && !copy) begin
						phase_q    <= PH_FLAG;
						lit_left_q <= '0;
						if (last) begin
							in_pos_q  <= '0;
							out_pos_q <= '0;
							wr_addr_q <= '0;
							offset_q  <= '0;
						end else begin
							absorb_q <= 1'b1;
						end
					end
				end
			end

			if (cmd.wr) begin
				beat_q[fill_q[1:0]] <= rdata;
				fill_q              <= fill_q + 3'd1;
				copy_left_q         <= copy_left_q - 8'd1;
				out_pos_q           <= out_pos_q + 11'd1;
				wr_addr_q           <= wr_addr_inc;
			end

			if (cmd.push) begin
				out_valid_q <= 1'b1;
				out_b_q     <= beat_q;
				count_q     <= fill_q;
				run_last_q  <= copy_left_q == 8'd0;
				done_q      <= (copy_left_q == 8'd0) && last_q;
				status_q    <= STAT_OK;
				total_q     <= ((copy_left_q == 8'd0) && last_q) ? out_pos_q : 11'd0;
				fill_q      <= '0;
				beat_q      <= '{default: 8'd0};
				if (copy_left_q == 8'd0 && last_q) begin
					in_pos_q  <= '0;
					out_pos_q <= '0;
					wr_addr_q <= '0;
					offset_q  <= '0;
					last_q    <= 1'b0;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte0  = out_b_q[0];
	assign out_byte1  = out_b_q[1];
	assign out_byte2  = out_b_q[2];
	assign out_byte3  = out_b_q[3];
	assign byte_count = count_q;
	assign run_last   = run_last_q;
	assign frame_done = done_q;
	assign status     = status_q;
	assign total_out  = total_q;

endmodule

// File: src/lz77_byte_decompressor.sv
// Top level of the LZ77 byte decompressor: controller, datapath and assertions.
// Depends on lzd_pkg, lzd_ctrl, lzd_dp and lzd_ram.
`timescale 1ns / 1ps

// The block decodes one frame of in_length compressed bytes, one byte per input
// transfer. Flag, offset and literal bytes are taken as long as the output
// register is free or is being emptied in the same cycle; a literal byte yields a
// one-byte beat. A length byte starts a copy from the history RAM: each copied
// byte is a registered read followed by the write-back of that byte, and each
// beat of up to four bytes is handed over once the output register is free. The
// input is held until the copy ends. The history RAM has one write and one read
// port. Each input transfer ends with run_last on its final result; the frame's
// final result carries frame_done, status and total_out. After an error the rest
// of the frame is consumed with no results. The history holds nothing valid after
// reset and is only ever read at positions written earlier in the same frame, so
// it needs no clearing pass. Configuration writes are taken at any time but are
// meant for idle periods between frames.
module lz77_byte_decompressor #(
	parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
	parameter int BEAT_BYTES    = lzd_pkg::BEAT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte0,
	output logic [7:0]  out_byte1,
	output logic [7:0]  out_byte2,
	output logic [7:0]  out_byte3,
	output logic [2:0]  byte_count,
	output logic        run_last,
	output logic        frame_done,
	output logic [2:0]  status,
	output logic [10:0] total_out
);

	import lzd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	// The controller only sequences; all decoding and storage lives in the datapath.
	lzd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	lzd_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.BEAT_BYTES   (BEAT_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_byte   (in_byte),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte0 (out_byte0),
		.out_byte1 (out_byte1),
		.out_byte2 (out_byte2),
		.out_byte3 (out_byte3),
		.byte_count(byte_count),
		.run_last  (run_last),
		.frame_done(frame_done),
		.status    (status),
		.total_out (total_out),
		.cmd       (cmd),
		.st        (st)
	);

`ifndef SYNTHESIS
	// A frame always ends on the last result of its input transfer.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("frame_done without run_last");

	// A nonzero status only ever appears on the frame's final result.
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> frame_done)
		else $error("status set before frame end");

	// A reference or overflow error result carries no decoded bytes.
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_REF || status == STAT_OVFL) |-> byte_count == 3'd0)
		else $error("error result carries bytes");

	// Input is never taken while a copy is being sequenced.
	a_no_accept_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd || cmd.wr || cmd.push |-> in_stall)
		else $error("input open during copy");
`endif

endmodule
